[src/smra_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor map running average package
// Shared constants, codes, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package smra_pkg;

	localparam int DATA_W    = 16;
	localparam int SLOT_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_BITS  = 4;

	localparam logic signed [DATA_W-1:0] MAX_TEMP_RST = 16'sd5120;
	localparam logic signed [DATA_W-1:0] MIN_TEMP_RST = 16'sd2560;

	localparam logic REQ_MAP_WRITE = 1'b0;
	localparam logic REQ_SAMPLE    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 2'd1;

	typedef enum logic [1:0] {
		ALARM_NONE = 2'd0,
		ALARM_HOT  = 2'd1,
		ALARM_COLD = 2'd2
	} alarm_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DIVIDE,
		ST_HIT,
		ST_MISS
	} state_t;

	typedef struct packed {
		logic capture;
		logic scan_step;
		logic hist_rd;
		logic update;
		logic div_step;
		logic load_hit;
		logic load_miss;
	} smra_cmd_t;

	typedef struct packed {
		logic match;
		logic last;
		logic div_last;
		logic out_free;
	} smra_sts_t;

endpackage

`default_nettype wire

[src/smra_if.sv]
// ----------------------------------------------------------------------------
// Sensor map running average channel interfaces
// Request, response and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface smra_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [3:0]  map_slot;
	logic [15:0] sensor_tag;
	logic [15:0] room_id;
	logic signed [15:0] sample_value;

	modport source (output valid, req_type, map_slot, sensor_tag, room_id, sample_value,
		input ready);
	modport sink (input valid, req_type, map_slot, sensor_tag, room_id, sample_value,
		output ready);
	modport mon (input valid, ready, req_type, map_slot, sensor_tag, room_id, sample_value);
endinterface

interface smra_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [15:0] room_out;
	logic signed [15:0] average;
	logic [1:0]  alarm;

	modport source (output valid, found, room_out, average, alarm, input ready);
	modport sink (input valid, found, room_out, average, alarm, output ready);
	modport mon (input valid, ready, found, room_out, average, alarm);
endinterface

interface smra_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport mon (input valid, ready, index, data);
endinterface

`default_nettype wire

[src/sensor_map_running_average_alarm.sv]
// ----------------------------------------------------------------------------
// Sensor map running average alarm
// Maps sensor ids to rooms, keeps a moving window of samples for each mapped
// sensor and reports the window average with a hot or cold alarm.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction
//  req      in         map write (no response) or sample (one response)
//  rsp      out        found, room_out, average, alarm
//  cfg      in         write of max_temp (index 0) or min_temp (index 1)
//
// A map write does not hold off the next request. The entry scan checks one entry
// per cycle and the divider yields four quotient bits per cycle.
// After reset the map is empty and the thresholds hold their default values.
// A response waits in the output register while the next request is accepted;
// the block stalls only when a new response is ready before the last is taken.
`default_nettype none

module sensor_map_running_average_alarm
	import smra_pkg::*;
#(
	parameter int MAP_ENTRIES = 16,
	parameter int WINDOW_LEN  = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	smra_req_if.sink   req,
	smra_rsp_if.source rsp,
	smra_cfg_if.sink   cfg
);

	smra_cmd_t cmd;
	smra_sts_t sts;

	smra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.sts    (sts),
		.cmd    (cmd)
	);

	smra_datapath #(
		.MAP_ENTRIES (MAP_ENTRIES),
		.WINDOW_LEN  (WINDOW_LEN)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

`default_nettype wire

[src/smra_ctrl.sv]
// ----------------------------------------------------------------------------
// Sensor map running average controller
// Sequences one request at a time: map lookup, window update and division on a
// match, and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smra_ctrl
	import smra_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	smra_req_if.sink   req,
	input  smra_sts_t  sts,
	output smra_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid && (req.req_type == REQ_SAMPLE)) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (sts.match) begin
					state_nxt = ST_UPDATE;
				end else if (sts.last) begin
					state_nxt = ST_MISS;
				end
			end
			ST_UPDATE: begin
				state_nxt = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (sts.div_last) begin
					state_nxt = ST_HIT;
				end
			end
			ST_HIT, ST_MISS: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready   = 1'b1;
				cmd.capture = req.valid;
			end
			ST_SCAN: begin
				cmd.scan_step = !sts.match;
				cmd.hist_rd   = sts.match;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_HIT: begin
				cmd.load_hit = sts.out_free;
			end
			ST_MISS: begin
				cmd.load_miss = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

[src/smra_datapath.sv]
// ----------------------------------------------------------------------------
// Sensor map running average datapath
// Map entries, per-entry window state, sample history memory, the divider
// for the window average, the threshold registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smra_datapath
	import smra_pkg::*;
#(
	parameter int MAP_ENTRIES = 16,
	parameter int WINDOW_LEN  = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	smra_req_if.sink   req,
	smra_rsp_if.source rsp,
	smra_cfg_if.sink   cfg,
	input  smra_cmd_t  cmd,
	output smra_sts_t  sts
);

	localparam int NUM_SLOTS  = (MAP_ENTRIES < (1 << SLOT_W)) ? MAP_ENTRIES : (1 << SLOT_W);
	localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
	localparam int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SUM_W      = DATA_W + 1 + ((WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 0);
	localparam int HIST_DEPTH = NUM_SLOTS * WINDOW_LEN;
	localparam int HA_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int DIV_STEPS  = (SUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W      = DIV_STEPS * DIV_BITS;
	localparam int CNT_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int REM_W      = FILL_W + 1;

	logic signed [DATA_W-1:0] max_temp_q;
	logic signed [DATA_W-1:0] min_temp_q;

	logic [NUM_SLOTS-1:0]           valid_q;
	logic [DATA_W-1:0]              sensor_q [NUM_SLOTS];
	logic [DATA_W-1:0]              room_q   [NUM_SLOTS];
	logic [FILL_W-1:0]              fill_q   [NUM_SLOTS];
	logic [PTR_W-1:0]               ptr_q    [NUM_SLOTS];
	logic signed [SUM_W-1:0]        sum_q    [NUM_SLOTS];
	logic signed [DATA_W-1:0]       hist_mem [HIST_DEPTH];
	logic signed [DATA_W-1:0]       hist_rd_q;

	logic [DATA_W-1:0]              sid_q;
	logic signed [DATA_W-1:0]       sample_q;
	logic [IDX_W-1:0]               scan_idx_q;

	logic [REM_W-1:0]               rem_q;
	logic [DIV_W-1:0]               quo_q;
	logic [FILL_W-1:0]              divisor_q;
	logic                           neg_q;
	logic [CNT_W-1:0]               div_cnt_q;

	logic                           out_valid_q;
	logic                           found_q;
	logic [DATA_W-1:0]              room_out_q;
	logic signed [DATA_W-1:0]       average_q;
	logic [1:0]                     alarm_q;

	logic                           map_wr;
	logic [IDX_W-1:0]               slot_idx;
	logic [HA_W-1:0]                hist_addr;
	logic [FILL_W-1:0]              fill_cur;
	logic [PTR_W-1:0]               ptr_cur;
	logic                           full;
	logic signed [SUM_W-1:0]        old_ext;
	logic signed [SUM_W-1:0]        new_sum;
	logic [SUM_W-1:0]               mag;
	logic [REM_W-1:0]               rem_nxt;
	logic [DIV_W-1:0]               quo_nxt;
	logic signed [DATA_W-1:0]       avg;
	alarm_t                         alarm_nxt;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_temp_q <= MAX_TEMP_RST;
			min_temp_q <= MIN_TEMP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MAX_TEMP: max_temp_q <= cfg.data;
				CFG_MIN_TEMP: min_temp_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign map_wr   = cmd.capture && (req.req_type == REQ_MAP_WRITE) &&
		(32'(req.map_slot) < 32'(MAP_ENTRIES));
	assign slot_idx = req.map_slot[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (map_wr) begin
			valid_q[slot_idx] <= 1'b1;
		end
	end

	assign fill_cur  = fill_q[scan_idx_q];
	assign ptr_cur   = ptr_q[scan_idx_q];
	assign full      = (fill_cur == FILL_W'(WINDOW_LEN));
	assign hist_addr = HA_W'(scan_idx_q) * HA_W'(WINDOW_LEN) + HA_W'(ptr_cur);
	assign old_ext   = full ? SUM_W'(hist_rd_q) : '0;
	assign new_sum   = sum_q[scan_idx_q] - old_ext + SUM_W'(sample_q);
	assign mag       = new_sum[SUM_W-1] ? (SUM_W'(0) - new_sum) : new_sum;

	always_ff @(posedge clk) begin
		if (map_wr) begin
			sensor_q[slot_idx] <= req.sensor_tag;
			room_q[slot_idx]   <= req.room_id;
			fill_q[slot_idx]   <= '0;
			ptr_q[slot_idx]    <= '0;
			sum_q[slot_idx]    <= '0;
		end else if (cmd.update) begin
			fill_q[scan_idx_q] <= full ? fill_cur : fill_cur + FILL_W'(1);
			ptr_q[scan_idx_q]  <= (ptr_cur == PTR_W'(WINDOW_LEN - 1)) ? '0 :
				ptr_cur + PTR_W'(1);
			sum_q[scan_idx_q]  <= new_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hist_mem[hist_addr] <= sample_q;
		end
		if (cmd.hist_rd) begin
			hist_rd_q <= hist_mem[hist_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sid_q      <= req.sensor_tag;
			sample_q   <= req.sample_value;
			scan_idx_q <= '0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
	end

	assign sts.match    = valid_q[scan_idx_q] && (sensor_q[scan_idx_q] == sid_q);
	assign sts.last     = (scan_idx_q == IDX_W'(NUM_SLOTS - 1));
	assign sts.div_last = (div_cnt_q == CNT_W'(DIV_STEPS - 1));
	assign sts.out_free = !out_valid_q || rsp.ready;

	// Restoring division of the sum magnitude, DIV_BITS quotient bits per cycle.
	always_comb begin
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			rem_nxt = {rem_nxt[REM_W-2:0], quo_nxt[DIV_W-1]};
			quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
			if (rem_nxt >= {1'b0, divisor_q}) begin
				rem_nxt    = rem_nxt - {1'b0, divisor_q};
				quo_nxt[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rem_q     <= '0;
			quo_q     <= DIV_W'(mag);
			divisor_q <= full ? FILL_W'(WINDOW_LEN) : fill_cur + FILL_W'(1);
			neg_q     <= new_sum[SUM_W-1];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= rem_nxt;
			quo_q     <= quo_nxt;
			div_cnt_q <= div_cnt_q + CNT_W'(1);
		end
	end

	assign avg = neg_q ? (DATA_W'(0) - quo_q[DATA_W-1:0]) : quo_q[DATA_W-1:0];

	always_comb begin
		priority if (avg > max_temp_q) begin
			alarm_nxt = ALARM_HOT;
		end else if (avg < min_temp_q) begin
			alarm_nxt = ALARM_COLD;
		end else begin
			alarm_nxt = ALARM_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_hit || cmd.load_miss) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hit) begin
			found_q    <= 1'b1;
			room_out_q <= room_q[scan_idx_q];
			average_q  <= avg;
			alarm_q    <= alarm_nxt;
		end else if (cmd.load_miss) begin
			found_q    <= 1'b0;
			room_out_q <= '0;
			average_q  <= '0;
			alarm_q    <= ALARM_NONE;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.found    = found_q;
	assign rsp.room_out = room_out_q;
	assign rsp.average  = average_q;
	assign rsp.alarm    = alarm_q;

endmodule

`default_nettype wire

[src/smra_checker.sv]
// ----------------------------------------------------------------------------
// Sensor map running average checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

module smra_checker
	import smra_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	smra_req_if.sink   req,
	smra_rsp_if.source rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.average) && $stable(rsp.room_out))
		else $error("response changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.room_out == '0 && rsp.average == '0 &&
		rsp.alarm == ALARM_NONE)
		else $error("not-found response carries data");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.req_type == REQ_SAMPLE |=> !req.ready)
		else $error("request accepted while a sample is in progress");

	a_map_fast: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.req_type == REQ_MAP_WRITE |=> req.ready)
		else $error("map write did not complete in one cycle");

endmodule

bind sensor_map_running_average_alarm smra_checker u_smra_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Sensor map running average alarm testbench
// Drives map writes and samples through the request channel, keeps its own
// model of the sensor map, the sample windows and the thresholds, and checks
// every response field by field. The run moves through several threshold
// settings and several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
	import smra_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES     = 16;
	localparam int WIN         = 5;
	localparam int SETTLE      = 30;
	localparam int STUCK_LIMIT = 5000;
	localparam int PRINT_LIMIT = 100;

	typedef struct packed {
		logic                     req_type;
		logic [SLOT_W-1:0]        map_slot;
		logic [DATA_W-1:0]        sensor_tag;
		logic [DATA_W-1:0]        room_id;
		logic signed [DATA_W-1:0] sample_value;
	} sensor_req_t;

	typedef struct packed {
		logic                     found;
		logic [DATA_W-1:0]        room;
		logic signed [DATA_W-1:0] average;
		alarm_t                   alarm;
	} room_reading_t;

	logic clk;
	logic arst_n;

	smra_req_if req_ch ();
	smra_rsp_if rsp_ch ();
	smra_cfg_if cfg_ch ();

	sensor_map_running_average_alarm dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	sensor_req_t   pending_requests[$];
	room_reading_t expected_readings[$];

	int send_idle_pct;
	int rsp_stall_pct;
	int err_count;
	int stuck_cycles;

	logic signed [DATA_W-1:0] hot_limit;
	logic signed [DATA_W-1:0] cold_limit;
	logic                     map_valid[ENTRIES];
	logic [DATA_W-1:0]        map_sensor[ENTRIES];
	logic [DATA_W-1:0]        map_room[ENTRIES];
	int                       win_fill[ENTRIES];
	int                       win_ptr[ENTRIES];
	int                       win_sum[ENTRIES];
	logic signed [DATA_W-1:0] win_hist[ENTRIES][WIN];
	logic [DATA_W-1:0]        id_pool[8];

	sensor_req_t seen_req;
	logic        any_transaction;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= PRINT_LIMIT) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
	endtask

	function automatic void track_request(input sensor_req_t it);
		int hit;
		int slot;
		int avg;
		room_reading_t r;
		if (it.req_type == REQ_MAP_WRITE) begin
			slot = it.map_slot;
			map_valid[slot] = 1'b1;
			map_sensor[slot] = it.sensor_tag;
			map_room[slot] = it.room_id;
			win_fill[slot] = 0;
			win_ptr[slot] = 0;
			win_sum[slot] = 0;
			return;
		end
		hit = -1;
		for (int e = 0; e < ENTRIES; e++) begin
			if (hit < 0 && map_valid[e] && map_sensor[e] == it.sensor_tag) begin
				hit = e;
			end
		end
		r = '0;
		r.alarm = ALARM_NONE;
		if (hit >= 0) begin
			if (win_fill[hit] < WIN) begin
				win_fill[hit]++;
			end else begin
				win_sum[hit] -= int'(win_hist[hit][win_ptr[hit]]);
			end
			win_sum[hit] += int'(it.sample_value);
			win_hist[hit][win_ptr[hit]] = it.sample_value;
			win_ptr[hit] = (win_ptr[hit] + 1) % WIN;
			avg = win_sum[hit] / win_fill[hit];
			r.found = 1'b1;
			r.room = map_room[hit];
			r.average = avg[DATA_W-1:0];
			if (avg > int'(hot_limit)) begin
				r.alarm = ALARM_HOT;
			end else if (avg < int'(cold_limit)) begin
				r.alarm = ALARM_COLD;
			end
		end
		expected_readings.push_back(r);
	endfunction

	task automatic check_reading();
		room_reading_t want;
		if (expected_readings.size() == 0) begin
			report_mismatch("response with no sample waiting for one");
			return;
		end
		want = expected_readings.pop_front();
		if (rsp_ch.found !== want.found)
			report_mismatch($sformatf("found %0b, want %0b", rsp_ch.found, want.found));
		if (rsp_ch.room_out !== want.room)
			report_mismatch($sformatf("room_out %h, want %h", rsp_ch.room_out, want.room));
		if (rsp_ch.average !== want.average)
			report_mismatch($sformatf("average %0d, want %0d", rsp_ch.average,
				want.average));
		if (rsp_ch.alarm !== want.alarm)
			report_mismatch($sformatf("alarm %0d, want %0d", rsp_ch.alarm, want.alarm));
	endtask

	// Request driver: holds an offered transaction until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid && pending_requests.size() != 0) begin
				void'(pending_requests.pop_front());
			end
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_ch.valid <= 1'b1;
				req_ch.req_type <= pending_requests[0].req_type;
				req_ch.map_slot <= pending_requests[0].map_slot;
				req_ch.sensor_tag <= pending_requests[0].sensor_tag;
				req_ch.room_id <= pending_requests[0].room_id;
				req_ch.sample_value <= pending_requests[0].sample_value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			any_transaction = 1'b0;
			if (rsp_ch.valid && rsp_ch.ready) begin
				check_reading();
				any_transaction = 1'b1;
			end
			if (req_ch.valid && req_ch.ready) begin
				seen_req.req_type = req_ch.req_type;
				seen_req.map_slot = req_ch.map_slot;
				seen_req.sensor_tag = req_ch.sensor_tag;
				seen_req.room_id = req_ch.room_id;
				seen_req.sample_value = req_ch.sample_value;
				track_request(seen_req);
				any_transaction = 1'b1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					CFG_MAX_TEMP: hot_limit = cfg_ch.data;
					CFG_MIN_TEMP: cold_limit = cfg_ch.data;
					default: ;
				endcase
				any_transaction = 1'b1;
			end
			stuck_cycles = any_transaction ? 0 : stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("sensor_map_running_average_alarm verification failed");
				$finish;
			end
		end
	end

	task automatic push_map(input int slot, input logic [15:0] sid, input logic [15:0] rid);
		sensor_req_t it;
		it = '0;
		it.req_type = REQ_MAP_WRITE;
		it.map_slot = slot[SLOT_W-1:0];
		it.sensor_tag = sid;
		it.room_id = rid;
		pending_requests.push_back(it);
	endtask

	task automatic push_sample(input logic [15:0] sid, input logic signed [15:0] value);
		sensor_req_t it;
		it = '0;
		it.req_type = REQ_SAMPLE;
		it.sensor_tag = sid;
		it.room_id = 16'($urandom);
		it.sample_value = value;
		pending_requests.push_back(it);
	endtask

	task automatic add_random_items(input int n);
		sensor_req_t it;
		for (int k = 0; k < n; k++) begin
			it.req_type = ($urandom_range(99) < 15) ? REQ_MAP_WRITE : REQ_SAMPLE;
			it.map_slot = SLOT_W'($urandom_range(ENTRIES - 1));
			it.sensor_tag = ($urandom_range(99) < 85) ? id_pool[$urandom_range(7)]
				: 16'($urandom);
			it.room_id = 16'($urandom);
			case ($urandom_range(4))
				0, 1: it.sample_value = 16'($urandom);
				2, 3: it.sample_value = 16'(int'($urandom_range(8000)) - 2000);
				default: it.sample_value = $urandom_range(1) ? 16'h7FFF : 16'h8000;
			endcase
			pending_requests.push_back(it);
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_requests.size() != 0 || expected_readings.size() != 0 || req_ch.valid);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
		input logic [DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic start_phase(input logic [15:0] hot, input logic [15:0] cold,
		input int idle_pct, input int stall_pct);
		drain();
		write_threshold(CFG_MAX_TEMP, hot);
		write_threshold(CFG_MIN_TEMP, cold);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_MAP_WRITE;
		req_ch.map_slot = '0;
		req_ch.sensor_tag = '0;
		req_ch.room_id = '0;
		req_ch.sample_value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_MAX_TEMP;
		cfg_ch.data = '0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		err_count = 0;
		stuck_cycles = 0;
		hot_limit = MAX_TEMP_RST;
		cold_limit = MIN_TEMP_RST;
		for (int e = 0; e < ENTRIES; e++) begin
			map_valid[e] = 1'b0;
			win_fill[e] = 0;
			win_ptr[e] = 0;
			win_sum[e] = 0;
		end
		for (int i = 0; i < 8; i++) begin
			id_pool[i] = 16'($urandom);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Lookup in an empty map, extreme ids and rooms, a duplicate sensor id,
		// full windows at both ends of the range, averages on the thresholds,
		// a negative average that truncates toward zero, and a remapped entry.
		push_sample(16'h1234, 16'sd100);
		push_map(0, 16'h0000, 16'hFFFF);
		push_map(15, 16'hFFFF, 16'h0000);
		push_map(3, 16'h1234, 16'h5555);
		push_map(7, 16'h1234, 16'hAAAA);
		repeat (6) push_sample(16'h1234, 16'sh7FFF);
		repeat (6) push_sample(16'h1234, 16'sh8000);
		push_sample(16'hFFFF, 16'sd5120);
		push_sample(16'hFFFF, -16'sd32768);
		push_sample(16'h0000, 16'sd2560);
		push_sample(16'h0000, -16'sd5121);
		push_map(3, 16'hBEEF, 16'h0001);
		push_sample(16'h1234, 16'sd3000);
		add_random_items(300);

		start_phase(16'h7FFF, 16'h8000, 78, 0);
		add_random_items(300);

		start_phase(16'h8000, 16'h7FFF, 0, 78);
		add_random_items(300);

		// Thresholds crossed: an average above max and below min is hot.
		start_phase(-16'sd100, 16'sd100, 25, 25);
		push_map(9, 16'hC0DE, 16'h0909);
		push_sample(16'hC0DE, 16'sd0);
		add_random_items(300);

		start_phase(16'($urandom_range(6000, 4000)), 16'($urandom_range(3000, 1000)), 0, 0);
		add_random_items(300);

		drain();
		if (expected_readings.size() != 0) begin
			report_mismatch($sformatf("%0d responses never arrived", expected_readings.size()));
		end
		if (err_count == 0) begin
			$display("sensor_map_running_average_alarm verification clean");
		end else begin
			$display("sensor_map_running_average_alarm verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
src/smra_pkg.sv
src/smra_if.sv
src/smra_ctrl.sv
src/smra_datapath.sv
src/sensor_map_running_average_alarm.sv
src/smra_checker.sv
tb/tb_top.sv
